// ===== rtl/vcrf_pkg.sv =====
// Package for the video control register file: address map constants,
// field masks and colour extension function. No dependencies.
`default_nettype none
package vcrf_pkg;
    localparam logic [9:0] P_TEXT_A   = 10'h030;
    localparam logic [9:0] P_TEXT_B   = 10'h148;
    localparam logic [9:0] FB_BASE    = 10'h200;
    localparam logic [9:0] PAL_BASE   = 10'h300;
    localparam logic [15:0] SCREEN_INTERLACE = 16'h0080;

    // Configuration register indexes
    localparam logic [1:0] REG_CRT_HIGH_RATE = 2'd0;

    // Memory word layout: one 32-bit word per entry
    localparam int MEM_W = 32;

    typedef enum logic [1:0] {
        T_ST_IDLE = 2'd0,
        T_ST_READ = 2'd1,
        T_ST_OUT  = 2'd2
    } t_state;

    typedef enum logic [1:0] {
        T_LR_INTERLACED = 2'd0,
        T_LR_HIGH       = 2'd1,
        T_LR_NORMAL     = 2'd2
    } t_line_rate;

    // Colour low-bit extension
    function automatic logic [15:0] extend_colour(input logic [15:0] c);
        logic [15:0] r;
        r = c;
        if ((c & 16'hf000) != 16'h0) r = r | 16'h0c00;
        if ((c & 16'h03c0) != 16'h0) r = r | 16'h0020;
        if ((c & 16'h001e) != 16'h0) r = r | 16'h0001;
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/vcrf_if.sv =====
// Valid/ready channel interface carrying the request or result payload.
// No dependencies.
`default_nettype none
interface vcrf_req_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [9:0] port;
    logic [7:0] write_data;
    modport source (output valid, output action, output port, output write_data, input ready);
    modport sink   (input valid, input action, input port, input write_data, output ready);
endinterface

interface vcrf_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       decode_hit;
    logic [1:0] line_rate_mode;
    modport source (output valid, output read_data, output decode_hit,
                    output line_rate_mode, input ready);
    modport sink   (input valid, input read_data, input decode_hit,
                    input line_rate_mode, output ready);
endinterface
`default_nettype wire

// ===== rtl/video_control_register_file.sv =====
// Video control register file: one byte request in, one result out.
// Result valid in the OUT state, after decode/read in IDLE and modify/write in READ;
// a new request is taken only once the previous result is taken, since each request
// does a read-modify-write through the single RAM port; rsp.ready low holds the result.
// Reset: clearing pass writes every RAM entry with its reset value, one per
// cycle; no request taken then.
// Depends on vcrf_pkg, vcrf_if, vcrf_ram.
`default_nettype none
module video_control_register_file #(
    parameter int FRAMEBUFFER_COUNT = 4,
    parameter int PALETTE_ENTRIES   = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    vcrf_req_if.sink        req,
    vcrf_rsp_if.source      rsp,
    input  wire logic       psel,
    input  wire logic       penable,
    input  wire logic       pwrite,
    input  wire logic [1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    // Entry map: 0..17 scalar words, then 9 per framebuffer, then palette
    localparam int FB_REGS   = 9;
    localparam int FB_FIRST  = 18;
    localparam int PAL_FIRST = FB_FIRST + FB_REGS * FRAMEBUFFER_COUNT;
    localparam int DEPTH     = PAL_FIRST + PALETTE_ENTRIES;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Scalar entry indexes
    localparam logic [AW-1:0] E_TEXT_A = AW'(0);
    localparam logic [AW-1:0] E_TEXT_B = AW'(1);
    localparam logic [AW-1:0] E_SCREEN = AW'(2);
    localparam logic [AW-1:0] E_GRES   = AW'(3);
    localparam logic [AW-1:0] E_ICOMP  = AW'(4);
    localparam logic [AW-1:0] E_DCOMP  = AW'(5);
    localparam logic [AW-1:0] E_MASKM  = AW'(6);
    localparam logic [AW-1:0] E_PALM   = AW'(7);
    localparam logic [AW-1:0] E_BACK   = AW'(8);
    localparam logic [AW-1:0] E_PMASK  = AW'(9);
    localparam logic [AW-1:0] E_TC0    = AW'(10);
    localparam logic [AW-1:0] E_MB0    = AW'(13);

    // Framebuffer entry indexes, relative to the framebuffer's first entry
    localparam int FB_START  = 0;
    localparam int FB_WIDTH  = 1;
    localparam int FB_LENGTH = 2;
    localparam int FB_DOT    = 3;
    localparam int FB_OFSX   = 4;
    localparam int FB_OFSY   = 5;
    localparam int FB_DADDR  = 6;
    localparam int FB_DHGT   = 7;
    localparam int FB_DPOS   = 8;

    assign pready = 1'b1;

    // Config register
    logic r_crt_high_rate;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crt_high_rate <= 1'b0;
        end else if (psel && penable && pwrite && paddr == vcrf_pkg::REG_CRT_HIGH_RATE) begin
            r_crt_high_rate <= pwdata[0];
        end
    end
    assign prdata = (paddr == vcrf_pkg::REG_CRT_HIGH_RATE) ? {31'd0, r_crt_high_rate} : 32'd0;

    // Screen mode bit 7 mirror for the line rate output
    logic r_interlace;

    // ---------------- Decode ----------------
    logic            d_hit, d_rmw, d_rd, d_color, d_force0, d_locked;
    logic [AW-1:0]   d_addr;
    logic [1:0]      d_lane;
    logic [7:0]      d_mask;
    logic [9:0]      p;
    logic [4:0]      off;
    logic [2:0]      fbn;
    logic [9:0]      pal_i;

    always_comb begin
        p        = req.port;
        off      = p[4:0];
        fbn      = 3'(p[9:5] - 5'h10);
        pal_i    = (p - vcrf_pkg::PAL_BASE) >> 1;
        d_hit    = 1'b0;
        d_rmw    = 1'b0;
        d_rd     = 1'b0;
        d_color  = 1'b0;
        d_force0 = 1'b0;
        d_locked = 1'b0;
        d_addr   = '0;
        d_lane   = {1'b0, p[0]};
        d_mask   = 8'hff;
        if (p == vcrf_pkg::P_TEXT_A) begin
            d_hit = req.action; d_rmw = 1'b1; d_addr = E_TEXT_A; d_lane = 2'd0;
        end else if (p == vcrf_pkg::P_TEXT_B) begin
            d_hit = req.action; d_rmw = 1'b1; d_addr = E_TEXT_B; d_lane = 2'd0;
            d_force0 = 1'b1;
        end else if (p[9:4] == 6'h10) begin
            case (p[3:1])
                3'd0: begin d_addr = E_SCREEN; d_hit = 1'b1; d_rd = 1'b1; end
                3'd1: begin d_addr = E_GRES;   d_hit = 1'b1; d_rd = 1'b1; end
                3'd3: begin d_addr = E_ICOMP;  d_hit = req.action; end
                3'd4: begin d_addr = E_DCOMP;  d_hit = req.action; end
                3'd5: begin d_addr = E_MASKM;  d_hit = req.action; end
                3'd6: begin d_addr = E_PALM;   d_hit = 1'b1; d_rd = 1'b1; end
                3'd7: begin d_addr = E_BACK;   d_hit = req.action; d_color = 1'b1; end
                default: d_hit = 1'b0;
            endcase
            d_rmw = 1'b1;
        end else if (p[9:1] == 9'h088) begin
            d_addr = E_PMASK; d_hit = req.action; d_rmw = 1'b1;
        end else if (p[9:1] == 9'h092 || p[9:1] == 9'h093 || p[9:1] == 9'h097) begin
            d_addr = (p[9:1] == 9'h097) ? E_TC0 + AW'(2) : E_TC0 + AW'(p[1]);
            d_force0 = (p[9:1] == 9'h097) && !p[0];
            d_hit = req.action; d_rmw = 1'b1;
        end else if (p[9:3] == 7'h26) begin
            d_addr = E_MB0 + AW'(p[2:1]); d_hit = req.action; d_rmw = 1'b1;
        end else if (p >= vcrf_pkg::FB_BASE &&
                     p < vcrf_pkg::FB_BASE + 10'(32 * FRAMEBUFFER_COUNT)) begin
            d_locked = (fbn == 3'd1);
            d_rd  = 1'b1;
            d_hit = 1'b1;
            d_rmw = 1'b1;
            case (off)
                5'h00, 5'h01, 5'h02, 5'h03: begin
                    d_addr = AW'(FB_START); d_lane = off[1:0];
                    d_mask = (off == 5'h00) ? 8'hfc : (off == 5'h01) ? 8'hff : 8'h03;
                    if (off == 5'h03) d_locked = 1'b1;
                end
                5'h04, 5'h05: begin
                    d_addr = AW'(FB_WIDTH); d_lane = {1'b0, off[0]};
                    d_mask = off[0] ? 8'h07 : 8'hfc; d_locked = 1'b0;
                end
                5'h06, 5'h07: begin
                    d_addr = AW'(FB_LENGTH); d_lane = {1'b0, off[0]};
                    d_mask = off[0] ? 8'h03 : 8'hff;
                end
                5'h08: begin
                    d_addr = AW'(FB_DOT); d_lane = 2'd0; d_mask = 8'h1f; d_locked = 1'b0;
                end
                5'h09: begin
                    d_rmw = 1'b0; d_locked = 1'b0;
                end
                5'h0a, 5'h0b: begin
                    d_addr = AW'(FB_OFSX); d_lane = {1'b0, off[0]};
                    d_mask = off[0] ? 8'h07 : 8'hfc;
                end
                5'h0c, 5'h0d: begin
                    d_addr = AW'(FB_OFSY); d_lane = {1'b0, off[0]};
                    d_mask = off[0] ? 8'h03 : 8'hff;
                end
                5'h0e, 5'h0f, 5'h10, 5'h11: begin
                    d_addr = AW'(FB_DADDR); d_lane = 2'(off - 5'h0e);
                    d_mask = (off == 5'h0e) ? 8'hfc : (off == 5'h0f) ? 8'hff : 8'h03;
                    d_locked = (off == 5'h11);
                end
                5'h12, 5'h13: begin
                    d_addr = AW'(FB_DHGT); d_lane = {1'b0, off[0]};
                    d_mask = off[0] ? 8'h01 : 8'hff; d_locked = 1'b0;
                end
                5'h16, 5'h17: begin
                    d_addr = AW'(FB_DPOS); d_lane = {1'b0, off[0]};
                    d_mask = off[0] ? 8'h01 : 8'hff; d_locked = 1'b0;
                end
                default: begin
                    d_hit = 1'b0; d_rd = 1'b0; d_rmw = 1'b0; d_locked = 1'b0;
                end
            endcase
            d_addr = AW'(FB_FIRST) + AW'(FB_REGS) * AW'(fbn) + d_addr;
        end else if (p >= vcrf_pkg::PAL_BASE && pal_i < 10'(PALETTE_ENTRIES)) begin
            d_addr = AW'(PAL_FIRST) + AW'(pal_i); d_hit = req.action; d_rmw = 1'b1;
            d_color = 1'b1;
        end
        if (!req.action && !d_rd) d_hit = 1'b0;
    end

    // ---------------- Control ----------------
    vcrf_pkg::t_state r_state, n_state;
    logic          r_clr;
    logic [AW-1:0] r_clr_idx;
    logic          r_wr, r_hit, r_rmw, r_color, r_force0, r_locked;
    logic [AW-1:0] r_addr;
    logic [1:0]    r_lane;
    logic [7:0]    r_mask, r_wdata, r_rdata;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_wdata, ram_rdata, mod_word, clr_word;
    logic [7:0]    ins;
    logic          take;

    assign req.ready = (r_state == vcrf_pkg::T_ST_IDLE) && !r_clr;
    assign take      = req.valid && req.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            vcrf_pkg::T_ST_IDLE: if (take) n_state = vcrf_pkg::T_ST_READ;
            vcrf_pkg::T_ST_READ: n_state = vcrf_pkg::T_ST_OUT;
            vcrf_pkg::T_ST_OUT:  if (rsp.ready) n_state = vcrf_pkg::T_ST_IDLE;
            default:             n_state = vcrf_pkg::T_ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= vcrf_pkg::T_ST_IDLE;
            r_clr     <= 1'b1;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (r_clr) begin
                r_clr_idx <= r_clr_idx + AW'(1);
                if (r_clr_idx == AW'(DEPTH - 1)) r_clr <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_wr     <= req.action;
            r_hit    <= d_hit;
            r_rmw    <= d_rmw;
            r_color  <= d_color;
            r_force0 <= d_force0;
            r_locked <= d_locked;
            r_addr   <= d_addr;
            r_lane   <= d_lane;
            r_mask   <= d_mask;
            r_wdata  <= req.write_data;
        end
        if (r_state == vcrf_pkg::T_ST_READ) begin
            r_rdata <= r_rmw ? ram_rdata[8*r_lane +: 8] : 8'h00;
        end
    end

    // Reset values of the clearing pass
    always_comb begin
        clr_word = 32'd0;
        if (r_clr_idx == E_TC0 + AW'(2)) clr_word = 32'd1;
        if (FRAMEBUFFER_COUNT > 1) begin
            if (r_clr_idx == AW'(FB_FIRST + FB_REGS + FB_START)) clr_word = 32'hffffffff;
            if (r_clr_idx == AW'(FB_FIRST + FB_REGS + FB_LENGTH) ||
                r_clr_idx == AW'(FB_FIRST + FB_REGS + FB_OFSX) ||
                r_clr_idx == AW'(FB_FIRST + FB_REGS + FB_OFSY)) clr_word = 32'h0000ffff;
        end
    end

    // Byte-lane modify of the word read back, with colour extension for colour entries
    always_comb begin
        ins = (r_wdata | {7'd0, r_force0}) & r_mask;
        mod_word = ram_rdata;
        mod_word[8*r_lane +: 8] = ins;
        if (r_color) mod_word[15:0] = vcrf_pkg::extend_colour(mod_word[15:0]);
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_addr;
        ram_wdata = mod_word;
        if (r_clr) begin
            ram_we = 1'b1; ram_addr = r_clr_idx; ram_wdata = clr_word;
        end else if (r_state == vcrf_pkg::T_ST_IDLE) begin
            ram_addr = d_addr;
        end else if (r_state == vcrf_pkg::T_ST_READ) begin
            ram_we = r_wr && r_hit && r_rmw && !r_locked;
        end
    end

    vcrf_ram #(.WIDTH(vcrf_pkg::MEM_W), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    // Screen mode bit 7 tracks writes to the screen mode low byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interlace <= 1'b0;
        end else if (ram_we && !r_clr && r_addr == E_SCREEN && r_lane == 2'd0) begin
            r_interlace <= r_wdata[7];
        end
    end

    // Result
    assign rsp.valid      = (r_state == vcrf_pkg::T_ST_OUT);
    assign rsp.read_data  = r_wr ? 8'h00 : (r_hit ? r_rdata : 8'hff);
    assign rsp.decode_hit = r_hit;
    assign rsp.line_rate_mode = r_interlace ? vcrf_pkg::T_LR_INTERLACED :
                                (r_crt_high_rate ? vcrf_pkg::T_LR_HIGH : vcrf_pkg::T_LR_NORMAL);
endmodule
`default_nettype wire

// ===== rtl/vcrf_ram.sv =====
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module vcrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for video_control_register_file: directed table plus random bus requests,
// checked against an in-bench model of the register bank. Depends on vcrf_pkg, vcrf_if, video_control_register_file.
`default_nettype none
module tb_top;
    localparam logic       ACT_READ  = 1'b0;
    localparam logic       ACT_WRITE = 1'b1;
    localparam logic [9:0] P_SCREEN   = 10'h100;
    localparam logic [9:0] P_TRANS2   = 10'h12e;
    localparam logic [9:0] P_BACKDROP = 10'h10e;
    localparam logic [9:0] P_UNMAPPED = 10'h3ff;
    localparam int FB_COUNT  = 4;
    localparam int PAL_COUNT = 32;
    localparam int LATENCY   = 6;
    localparam int N_RANDOM  = 925;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    vcrf_req_if req_ch();
    vcrf_rsp_if rsp_ch();

    video_control_register_file #(.FRAMEBUFFER_COUNT(FB_COUNT), .PALETTE_ENTRIES(PAL_COUNT))
    i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .req(req_ch), .rsp(rsp_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    typedef struct packed {
        logic [7:0] read_data;
        logic       decode_hit;
        logic [1:0] line_rate;
    } t_bus_result;

    // Model copy of the register bank
    logic        crt_high;
    logic [31:0] text_a, text_b, scr_mode, gfx_res, idx_comp, dir_comp, msk_mode, pal_mode;
    logic [31:0] backdrop, plane_msk;
    logic [31:0] transp[3];
    logic [31:0] bounds[4];
    logic [31:0] palette[PAL_COUNT];
    logic [31:0] fb_start[FB_COUNT], fb_wid[FB_COUNT], fb_len[FB_COUNT], fb_dotc[FB_COUNT];
    logic [31:0] fb_ofx[FB_COUNT], fb_ofy[FB_COUNT], fb_daddr[FB_COUNT];
    logic [31:0] fb_dh[FB_COUNT], fb_dpos[FB_COUNT];

    t_bus_result expected_results[$];
    int errors = 0;
    int n_reads = 0, n_writes = 0, n_results = 0;
    int send_idle_pct = 0, recv_stall_pct = 0;

    function automatic logic [31:0] put_lane(logic [31:0] w, int lane, logic [7:0] d,
                                             logic [7:0] m);
        logic [31:0] r;
        r = w;
        r[lane*8 +: 8] = d & m;
        return r;
    endfunction

    function automatic logic [31:0] colour_fill(logic [31:0] c);
        logic [31:0] r;
        r = c & 32'hffff;
        if ((r & 32'hf000) != 0) r = r | 32'h0c00;
        if ((r & 32'h03c0) != 0) r = r | 32'h0020;
        if ((r & 32'h001e) != 0) r = r | 32'h0001;
        return r;
    endfunction

    task automatic reset_bank();
        crt_high = 1'b0;
        text_a = 0; text_b = 0; scr_mode = 0; gfx_res = 0; idx_comp = 0; dir_comp = 0;
        msk_mode = 0; pal_mode = 0; backdrop = 0; plane_msk = 0;
        transp[0] = 0; transp[1] = 0; transp[2] = 1;
        for (int i = 0; i < 4; i++) bounds[i] = 0;
        for (int i = 0; i < PAL_COUNT; i++) palette[i] = 0;
        for (int i = 0; i < FB_COUNT; i++) begin
            fb_start[i] = (i == 1) ? 32'hffffffff : 0;
            fb_len[i]   = (i == 1) ? 32'hffff : 0;
            fb_ofx[i]   = (i == 1) ? 32'hffff : 0;
            fb_ofy[i]   = (i == 1) ? 32'hffff : 0;
            fb_wid[i] = 0; fb_dotc[i] = 0; fb_daddr[i] = 0; fb_dh[i] = 0; fb_dpos[i] = 0;
        end
    endtask

    // Framebuffer register window; returns hit
    function automatic logic fb_window(logic wr, int n, logic [4:0] off, logic [7:0] d,
                                       output logic [7:0] rd);
        logic locked;
        locked = (n == 1);
        rd = 8'h00;
        case (off)
            5'h00, 5'h01, 5'h02, 5'h03: begin
                if (wr) begin
                    if (!locked && off != 5'h03)
                        fb_start[n] = put_lane(fb_start[n], off, d,
                            off == 0 ? 8'hfc : (off == 1 ? 8'hff : 8'h03));
                end else rd = fb_start[n][off*8 +: 8];
            end
            5'h04, 5'h05: begin
                if (wr) fb_wid[n] = put_lane(fb_wid[n], off - 4, d, off == 4 ? 8'hfc : 8'h07);
                else rd = fb_wid[n][(off - 4)*8 +: 8];
            end
            5'h06, 5'h07: begin
                if (wr) begin
                    if (!locked) fb_len[n] = put_lane(fb_len[n], off - 6, d,
                                                      off == 6 ? 8'hff : 8'h03);
                end else rd = fb_len[n][(off - 6)*8 +: 8];
            end
            5'h08: begin
                if (wr) fb_dotc[n] = d & 8'h1f;
                else rd = fb_dotc[n][7:0];
            end
            5'h09: ;
            5'h0a, 5'h0b: begin
                if (wr) begin
                    if (!locked) fb_ofx[n] = put_lane(fb_ofx[n], off - 10, d,
                                                      off == 10 ? 8'hfc : 8'h07);
                end else rd = fb_ofx[n][(off - 10)*8 +: 8];
            end
            5'h0c, 5'h0d: begin
                if (wr) begin
                    if (!locked) fb_ofy[n] = put_lane(fb_ofy[n], off - 12, d,
                                                      off == 12 ? 8'hff : 8'h03);
                end else rd = fb_ofy[n][(off - 12)*8 +: 8];
            end
            5'h0e, 5'h0f, 5'h10, 5'h11: begin
                if (wr) begin
                    if (off != 5'h11)
                        fb_daddr[n] = put_lane(fb_daddr[n], off - 14, d,
                            off == 14 ? 8'hfc : (off == 15 ? 8'hff : 8'h03));
                end else rd = fb_daddr[n][(off - 14)*8 +: 8];
            end
            5'h12, 5'h13: begin
                if (wr) fb_dh[n] = put_lane(fb_dh[n], off - 18, d, off == 18 ? 8'hff : 8'h01);
                else rd = fb_dh[n][(off - 18)*8 +: 8];
            end
            5'h16, 5'h17: begin
                if (wr) fb_dpos[n] = put_lane(fb_dpos[n], off - 22, d,
                                              off == 22 ? 8'hff : 8'h01);
                else rd = fb_dpos[n][(off - 22)*8 +: 8];
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // Apply one bus request to the model bank and work out its result
    function automatic t_bus_result bank_access(logic wr, logic [9:0] p, logic [7:0] d);
        t_bus_result r;
        logic [7:0] rd;
        logic hit;
        int lane;
        rd = 8'hff; hit = 1'b1; lane = p[0];
        case (p)
            vcrf_pkg::P_TEXT_A: if (wr) text_a = d; else hit = 0;
            vcrf_pkg::P_TEXT_B: if (wr) text_b = d | 8'h01; else hit = 0;
            10'h100, 10'h101: if (wr) scr_mode = put_lane(scr_mode, lane, d, 8'hff);
                              else rd = scr_mode[lane*8 +: 8];
            10'h102, 10'h103: if (wr) gfx_res = put_lane(gfx_res, lane, d, 8'hff);
                              else rd = gfx_res[lane*8 +: 8];
            10'h10c, 10'h10d: if (wr) pal_mode = put_lane(pal_mode, lane, d, 8'hff);
                              else rd = pal_mode[lane*8 +: 8];
            10'h106, 10'h107: if (wr) idx_comp = put_lane(idx_comp, lane, d, 8'hff); else hit = 0;
            10'h108, 10'h109: if (wr) dir_comp = put_lane(dir_comp, lane, d, 8'hff); else hit = 0;
            10'h10a, 10'h10b: if (wr) msk_mode = put_lane(msk_mode, lane, d, 8'hff); else hit = 0;
            10'h10e, 10'h10f:
                if (wr) backdrop = colour_fill(put_lane(backdrop, lane, d, 8'hff)); else hit = 0;
            10'h110, 10'h111: if (wr) plane_msk = put_lane(plane_msk, lane, d, 8'hff);
                              else hit = 0;
            10'h124, 10'h125: if (wr) transp[0] = put_lane(transp[0], lane, d, 8'hff); else hit = 0;
            10'h126, 10'h127: if (wr) transp[1] = put_lane(transp[1], lane, d, 8'hff); else hit = 0;
            10'h12e, 10'h12f:
                if (wr) transp[2] = put_lane(transp[2], lane, lane ? d : (d | 8'h01), 8'hff);
                else hit = 0;
            10'h130, 10'h131, 10'h132, 10'h133, 10'h134, 10'h135, 10'h136, 10'h137:
                if (wr) bounds[p[2:1]] = put_lane(bounds[p[2:1]], lane, d, 8'hff); else hit = 0;
            default: begin
                if (p >= vcrf_pkg::FB_BASE && p < vcrf_pkg::FB_BASE + 32 * FB_COUNT)
                    hit = fb_window(wr, (p - vcrf_pkg::FB_BASE) >> 5, p[4:0], d, rd);
                else if (p >= vcrf_pkg::PAL_BASE &&
                         p < vcrf_pkg::PAL_BASE + 2 * PAL_COUNT && wr)
                    palette[(p - vcrf_pkg::PAL_BASE) >> 1] =
                        colour_fill(put_lane(palette[(p - vcrf_pkg::PAL_BASE) >> 1],
                                             lane, d, 8'hff));
                else hit = 0;
            end
        endcase
        if (!hit) rd = 8'hff;
        if (wr) rd = 8'h00;
        r.read_data = rd;
        r.decode_hit = hit;
        if ((scr_mode & 32'(vcrf_pkg::SCREEN_INTERLACE)) != 0)
            r.line_rate = vcrf_pkg::T_LR_INTERLACED;
        else r.line_rate = crt_high ? vcrf_pkg::T_LR_HIGH : vcrf_pkg::T_LR_NORMAL;
        return r;
    endfunction

    // Directed stimulus; chk marks rows with a typed-in expectation
    typedef struct {
        logic       wr;
        logic [9:0] p;
        logic [7:0] d;
        logic       chk;
        logic [7:0] rd;
        logic       hit;
    } t_dir_row;

    t_dir_row dir_rows[] = '{
        '{ACT_READ,  P_SCREEN,    8'h00, 1, 8'h00, 1},  // screen mode after reset
        '{ACT_READ,  10'h220,     8'h00, 1, 8'hff, 1},  // fb 1 start, all ones
        '{ACT_READ,  10'h22d,     8'h00, 1, 8'hff, 1},  // fb 1 offset y high
        '{ACT_READ,  vcrf_pkg::P_TEXT_A, 8'h00, 1, 8'hff, 0},  // write-only
        '{ACT_WRITE, vcrf_pkg::P_TEXT_A, 8'hff, 1, 8'h00, 1},
        '{ACT_READ,  P_UNMAPPED,  8'h00, 1, 8'hff, 0},
        '{ACT_WRITE, P_UNMAPPED,  8'hff, 1, 8'h00, 0},
        '{ACT_WRITE, P_SCREEN,    8'h80, 1, 8'h00, 1},  // interlaced
        '{ACT_READ,  P_SCREEN,    8'h00, 1, 8'h80, 1},
        '{ACT_WRITE, 10'h220,     8'h00, 1, 8'h00, 1},  // fb 1 locked
        '{ACT_READ,  10'h220,     8'h00, 1, 8'hff, 1},
        '{ACT_WRITE, vcrf_pkg::P_TEXT_B, 8'h00, 1, 8'h00, 1},
        '{ACT_WRITE, P_TRANS2,    8'h00, 1, 8'h00, 1},
        '{ACT_WRITE, vcrf_pkg::PAL_BASE, 8'hff, 0, 8'h00, 0},
        '{ACT_WRITE, 10'h33f,     8'h10, 0, 8'h00, 0},  // last palette entry
        '{ACT_WRITE, 10'h340,     8'hff, 1, 8'h00, 0},  // past the palette
        '{ACT_WRITE, P_BACKDROP,  8'h1e, 0, 8'h00, 0},
        '{ACT_WRITE, 10'h208,     8'hff, 0, 8'h00, 0},
        '{ACT_READ,  10'h208,     8'h00, 1, 8'h1f, 1},
        '{ACT_READ,  10'h209,     8'h00, 1, 8'h00, 1},
        '{ACT_READ,  10'h211,     8'h00, 1, 8'h00, 1},
        '{ACT_READ,  10'h214,     8'h00, 1, 8'hff, 0},  // hole in fb map
        '{ACT_WRITE, 10'h277,     8'hff, 0, 8'h00, 0},
        '{ACT_READ,  10'h277,     8'h00, 1, 8'h01, 1},
        '{ACT_WRITE, P_SCREEN,    8'h00, 0, 8'h00, 0}
    };

    // Send one request and book its expectation on acceptance
    task automatic send_request(logic wr, logic [9:0] p, logic [7:0] d, logic chk,
                                logic [7:0] rd, logic hit);
        t_bus_result r;
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.action <= wr;
        req_ch.port <= p;
        req_ch.write_data <= d;
        do @(posedge i_clk); while (!req_ch.ready);
        r = bank_access(wr, p, d);
        if (chk) begin
            r.read_data = rd;
            r.decode_hit = hit;
        end
        expected_results.push_back(r);
        if (wr) n_writes++; else n_reads++;
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_crt_rate(logic v);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= vcrf_pkg::REG_CRT_HIGH_RATE;
        pwdata <= {31'b0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        crt_high = v;
    endtask

    // Random port, weighted toward mapped regions
    function automatic logic [9:0] pick_port();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40) return vcrf_pkg::FB_BASE + 10'($urandom_range(32 * FB_COUNT - 1));
        if (sel < 60) return 10'h100 + 10'($urandom_range(10'h4f));
        if (sel < 75) return vcrf_pkg::PAL_BASE + 10'($urandom_range(2 * PAL_COUNT + 3));
        if (sel < 85) return ($urandom_range(1) != 0) ? vcrf_pkg::P_TEXT_A : vcrf_pkg::P_TEXT_B;
        return 10'($urandom_range(1023));
    endfunction

    // Result channel: stall and check
    always @(posedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_bus_result e;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            n_results++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result rd=%h hit=%b lr=%0d", $time,
                         rsp_ch.read_data, rsp_ch.decode_hit, rsp_ch.line_rate_mode);
            end else begin
                e = expected_results.pop_front();
                if (rsp_ch.read_data !== e.read_data) begin
                    errors++;
                    $display("%0t: read_data expected %h actual %h", $time,
                             e.read_data, rsp_ch.read_data);
                end
                if (rsp_ch.decode_hit !== e.decode_hit) begin
                    errors++;
                    $display("%0t: decode_hit expected %b actual %b", $time,
                             e.decode_hit, rsp_ch.decode_hit);
                end
                if (rsp_ch.line_rate_mode !== e.line_rate) begin
                    errors++;
                    $display("%0t: line_rate_mode expected %0d actual %0d", $time,
                             e.line_rate, rsp_ch.line_rate_mode);
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Timeout at %0t", $time);
        $display("Regression FAIL");
        $finish;
    end

    // Main sequence
    initial begin
        req_ch.valid = 1'b0;
        req_ch.action = ACT_READ;
        req_ch.port = '0;
        req_ch.write_data = '0;
        rsp_ch.ready = 1'b0;
        reset_bank();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k])
            send_request(dir_rows[k].wr, dir_rows[k].p, dir_rows[k].d, dir_rows[k].chk,
                         dir_rows[k].rd, dir_rows[k].hit);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            write_crt_rate(ph != 1);
            send_idle_pct  = (ph == 0) ? 13 : (ph == 1) ? 64 : 0;
            recv_stall_pct = (ph == 0) ? 64 : (ph == 1) ? 13 : 0;
            for (int k = 0; k < N_RANDOM / 3; k++) begin
                if (ph == 0 && k == 150) drain();
                send_request($urandom_range(1), pick_port(), 8'($urandom_range(255)),
                             1'b0, 8'h00, 1'b0);
            end
            drain();
        end

        $display("Covered %0d reads and %0d writes, %0d results, both line-rate settings",
                 n_reads, n_writes, n_results);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/vcrf_pkg.sv
rtl/vcrf_if.sv
rtl/vcrf_ram.sv
rtl/video_control_register_file.sv
verif/tb_top.sv
